// File: rtl/gusd_pkg.sv
// ----------------------------------------------------------------------------
// gusd_pkg: shared types and codes of the UBX / RTCM3 stream deframer
// Event and route codes, field widths and the result record that the
// parser core hands to the output stage of the top level.
// ----------------------------------------------------------------------------
package gusd_pkg;

  localparam int unsigned CountW = 11;

  // Event codes reported with every result.
  localparam logic [2:0] EvPayload  = 3'd0;
  localparam logic [2:0] EvUbxGood  = 3'd1;
  localparam logic [2:0] EvUbxBadCk = 3'd2;
  localparam logic [2:0] EvUbxLenRj = 3'd3;
  localparam logic [2:0] EvRtcmSkip = 3'd4;

  // Routing codes, meaningful only with a good UBX frame.
  localparam logic [1:0] RouteNone = 2'd0;
  localparam logic [1:0] RoutePvt  = 2'd1;
  localparam logic [1:0] RouteCov  = 2'd2;

  // Protocol bytes.
  localparam logic [7:0] UbxSync1  = 8'hB5;
  localparam logic [7:0] UbxSync2  = 8'h62;
  localparam logic [7:0] RtcmPre   = 8'hD3;
  localparam logic [7:0] ClassNav  = 8'h01;
  localparam logic [7:0] IdentPvt  = 8'h07;
  localparam logic [7:0] IdentCov  = 8'h36;

  typedef struct packed {
    logic [2:0]  event_res;
    logic [7:0]  payload_byte;
    logic [9:0]  payload_offset;
    logic [7:0]  msg_class;
    logic [7:0]  msg_ident;
    logic [15:0] frame_length;
    logic [1:0]  route;
  } result_t;

endpackage

// File: rtl/gusd_core.sv
// ----------------------------------------------------------------------------
// gusd_core: byte-wise frame parser
// Holds the frame state, Fletcher sums and latched header fields, and
// produces at most one result for each accepted byte in the same cycle.
// ----------------------------------------------------------------------------
module gusd_core #(
  parameter int unsigned MAX_PAYLOAD = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        byte_i,
  input  logic              cov_en_i,
  output logic              res_valid_o,
  output gusd_pkg::result_t res_o
);
  import gusd_pkg::*;

  localparam logic [15:0] MaxLen = 16'(MAX_PAYLOAD);

  typedef enum logic [3:0] {
    PhHunt, PhSync2, PhClass, PhIdent, PhLenLo, PhLenHi, PhPayload,
    PhCkA, PhCkB, PhRtLenHi, PhRtLenLo, PhRtBody
  } phase_e;

  phase_e             phase_q, phase_d;
  logic [7:0]         class_q, class_d;
  logic [7:0]         ident_q, ident_d;
  logic [15:0]        length_q, length_d;
  logic [CountW-1:0]  count_q, count_d;
  logic [7:0]         sum_a_q, sum_a_d;
  logic [7:0]         sum_b_q, sum_b_d;
  logic [7:0]         ck_a_q, ck_a_d;

  logic [7:0]         fl_a, fl_b;
  logic [CountW-1:0]  count_inc;
  logic [15:0]        len_hi;
  logic [16:0]        rt_total;
  phase_e             start_ph;

  assign fl_a      = sum_a_q + byte_i;
  assign fl_b      = sum_b_q + fl_a;
  assign count_inc = count_q + CountW'(1);
  assign len_hi    = {byte_i, length_q[7:0]};
  assign rt_total  = {1'b0, length_q} + 17'd3;

  always_comb begin
    if (byte_i == UbxSync1) begin
      start_ph = PhSync2;
    end else if (byte_i == RtcmPre) begin
      start_ph = PhRtLenHi;
    end else begin
      start_ph = PhHunt;
    end
  end

  always_comb begin
    phase_d  = phase_q;
    class_d  = class_q;
    ident_d  = ident_q;
    length_d = length_q;
    count_d  = count_q;
    sum_a_d  = sum_a_q;
    sum_b_d  = sum_b_q;
    ck_a_d   = ck_a_q;
    res_valid_o = 1'b0;
    res_o = '{event_res: EvPayload, payload_byte: 8'd0, payload_offset: 10'd0,
              msg_class: class_q, msg_ident: ident_q, frame_length: length_q,
              route: RouteNone};
    case (phase_q)
      PhSync2: begin
        if (byte_i == UbxSync2) begin
          sum_a_d = 8'd0;
          sum_b_d = 8'd0;
          phase_d = PhClass;
        end else begin
          phase_d = start_ph;
        end
      end
      PhClass: begin
        class_d = byte_i;
        sum_a_d = fl_a;
        sum_b_d = fl_b;
        phase_d = PhIdent;
      end
      PhIdent: begin
        ident_d = byte_i;
        sum_a_d = fl_a;
        sum_b_d = fl_b;
        phase_d = PhLenLo;
      end
      PhLenLo: begin
        length_d = {8'd0, byte_i};
        sum_a_d  = fl_a;
        sum_b_d  = fl_b;
        phase_d  = PhLenHi;
      end
      PhLenHi: begin
        length_d = len_hi;
        sum_a_d  = fl_a;
        sum_b_d  = fl_b;
        count_d  = '0;
        if (len_hi > MaxLen) begin
          phase_d = PhHunt;
          res_valid_o = 1'b1;
          res_o.event_res    = EvUbxLenRj;
          res_o.frame_length = len_hi;
        end else if (len_hi == 16'd0) begin
          phase_d = PhCkA;
        end else begin
          phase_d = PhPayload;
        end
      end
      PhPayload: begin
        sum_a_d = fl_a;
        sum_b_d = fl_b;
        count_d = count_inc;
        if ({5'd0, count_inc} >= length_q) begin
          phase_d = PhCkA;
        end
        res_valid_o = 1'b1;
        res_o.payload_byte   = byte_i;
        res_o.payload_offset = count_q[9:0];
      end
      PhCkA: begin
        ck_a_d  = byte_i;
        phase_d = PhCkB;
      end
      PhCkB: begin
        phase_d = PhHunt;
        res_valid_o = 1'b1;
        if (ck_a_q == sum_a_q && byte_i == sum_b_q) begin
          res_o.event_res = EvUbxGood;
          if (class_q == ClassNav && ident_q == IdentPvt) begin
            res_o.route = RoutePvt;
          end else if (class_q == ClassNav && ident_q == IdentCov && cov_en_i) begin
            res_o.route = RouteCov;
          end
        end else begin
          res_o.event_res = EvUbxBadCk;
        end
      end
      PhRtLenHi: begin
        length_d = {6'd0, byte_i[1:0], 8'd0};
        phase_d  = PhRtLenLo;
      end
      PhRtLenLo: begin
        length_d = {length_q[15:8], byte_i};
        count_d  = '0;
        phase_d  = PhRtBody;
      end
      PhRtBody: begin
        count_d = count_inc;
        if ({6'd0, count_inc} >= rt_total) begin
          phase_d = PhHunt;
          res_valid_o = 1'b1;
          res_o.event_res = EvRtcmSkip;
          res_o.msg_class = 8'd0;
          res_o.msg_ident = 8'd0;
        end
      end
      default: begin
        phase_d = start_ph;
      end
    endcase
    if (!accept_i) begin
      res_valid_o = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhHunt;
      class_q  <= '0;
      ident_q  <= '0;
      length_q <= '0;
      count_q  <= '0;
      sum_a_q  <= '0;
      sum_b_q  <= '0;
      ck_a_q   <= '0;
    end else if (accept_i) begin
      phase_q  <= phase_d;
      class_q  <= class_d;
      ident_q  <= ident_d;
      length_q <= length_d;
      count_q  <= count_d;
      sum_a_q  <= sum_a_d;
      sum_b_q  <= sum_b_d;
      ck_a_q   <= ck_a_d;
    end
  end

endmodule

// File: rtl/gnss_ubx_rtcm_stream_deframer.sv
// ----------------------------------------------------------------------------
// gnss_ubx_rtcm_stream_deframer: UBX / RTCM3 byte stream deframer
// Splits a receiver byte stream into UBX payload bytes and frame events.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (rx_valid_i, rx_stall_o, rx_byte_i) takes one received
// byte per transfer. The result channel (res_valid_o, res_stall_i and the
// field ports) delivers zero or one result per byte: each UBX payload byte
// with its offset, and one event at the end of every UBX frame (good
// checksum, bad checksum, rejected length) or skipped RTCM3 frame.
// A byte is parsed in the cycle it is accepted and its result is registered
// in the output register, or in the skid register while the output is held,
// and a new byte can be taken in every cycle while rx_stall_o is low.
// When the receiver stalls, the held result stays on the output register and
// one further result is caught in a skid register; rx_stall_o is high while
// that skid register is full. Reset returns the parser to hunting for sync,
// clears both output stages and disables covariance routing. The covariance
// enable lives at APB byte address 0; the user must write it only while the
// block is idle, and the block itself does not enforce this.
// ----------------------------------------------------------------------------
module gnss_ubx_rtcm_stream_deframer #(
  parameter int unsigned MAX_PAYLOAD = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Byte input channel.
  input  logic        rx_valid_i,
  output logic        rx_stall_o,
  input  logic [7:0]  rx_byte_i,
  // Result channel.
  output logic        res_valid_o,
  input  logic        res_stall_i,
  output logic [2:0]  event_res_o,
  output logic [7:0]  payload_byte_o,
  output logic [9:0]  payload_offset_o,
  output logic [7:0]  msg_class_o,
  output logic [7:0]  msg_ident_o,
  output logic [15:0] frame_length_o,
  output logic [1:0]  route_o,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import gusd_pkg::*;

  logic    cov_en_q;
  logic    rx_accept;
  logic    core_valid;
  result_t core_res;

  // Output register plus one skid entry.
  logic    res_valid_q, skid_valid_q;
  result_t res_q, skid_q;
  logic    res_take;

  // The register decode ignores the byte lane bits of the address.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {31'd0, cov_en_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cov_en_q <= 1'b0;
    end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
      cov_en_q <= pwdata[0];
    end
  end

  // The input is held off only while the skid entry is occupied.
  assign rx_stall_o = skid_valid_q;
  assign rx_accept  = rx_valid_i && !skid_valid_q;

  gusd_core #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (rx_accept),
    .byte_i     (rx_byte_i),
    .cov_en_i   (cov_en_q),
    .res_valid_o(core_valid),
    .res_o      (core_res)
  );

  assign res_take = res_valid_q && !res_stall_i;

  // When the output register frees up it is refilled from the skid entry
  // first, which keeps results in order; a new result lands in the skid
  // entry only while the output register is held by a stall.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!res_valid_q || res_take) begin
      if (skid_valid_q) begin
        res_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        res_valid_q  <= core_valid;
      end
    end else if (core_valid) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!res_valid_q || res_take) begin
      res_q <= skid_valid_q ? skid_q : core_res;
    end else if (core_valid) begin
      skid_q <= core_res;
    end
  end

  assign res_valid_o      = res_valid_q;
  assign event_res_o      = res_q.event_res;
  assign payload_byte_o   = res_q.payload_byte;
  assign payload_offset_o = res_q.payload_offset;
  assign msg_class_o      = res_q.msg_class;
  assign msg_ident_o      = res_q.msg_ident;
  assign frame_length_o   = res_q.frame_length;
  assign route_o          = res_q.route;

`ifndef SYNTHESIS
  // The skid entry is only ever filled behind a held output register.
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> res_valid_q)
    else $error("skid entry occupied with empty output register");

  // A route is only reported with a good frame.
  a_route_only_good: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && route_o != RouteNone) |-> (event_res_o == EvUbxGood))
    else $error("route reported without a good frame");

  // Payload data fields are zero on every frame event.
  a_payload_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && event_res_o != EvPayload) |->
      (payload_byte_o == 8'd0 && payload_offset_o == 10'd0))
    else $error("payload fields set on a frame event");

  // A rejected length is always above the payload limit.
  a_reject_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && event_res_o == EvUbxLenRj) |->
      (frame_length_o > 16'(MAX_PAYLOAD)))
    else $error("length rejected within the payload limit");
`endif

endmodule

// File: tb/sv/gnss_ubx_rtcm_stream_deframer_test.sv
// ----------------------------------------------------------------------------
// gnss_ubx_rtcm_stream_deframer_test: self-checking bench for the deframer
// Feeds the deframer a receiver byte stream (a short scripted opening, then
// random UBX frames, RTCM3 frames, rejected headers, cut-off headers and
// line noise) and checks every result against an in-bench model of the
// parser, with random idle bursts on both channels and one long hold-off.
// ----------------------------------------------------------------------------
module gnss_ubx_rtcm_stream_deframer_test;
  import gusd_pkg::*;

  localparam int unsigned MaxPayload = 1024;

  // Byte address of the covariance routing enable register.
  localparam logic [2:0] CovEnAddr = 3'd0;

  // Length of the receiver hold-off that forces the deframer to fill up.
  localparam int unsigned LongHoldCycles = 80;

  // Cycles allowed after the last expected result before the bench treats
  // the deframer as idle, covering the output register plus the skid stage.
  localparam int unsigned SettleCycles = 4;

  // Phases of the parser, mirroring the deframer's own sequencing.
  typedef enum logic [3:0] {
    PhHunt, PhSync2, PhClass, PhIdent, PhLenLo, PhLenHi, PhPayload,
    PhCkA, PhCkB, PhRtLenHi, PhRtLenLo, PhRtBody
  } parse_phase_e;

  // One row of the scripted opening: a byte, and where the outcome is plain
  // to see, the result that byte must produce.
  typedef struct packed {
    logic [7:0] rx;
    logic       typed;
    result_t    res;
  } stim_row_t;

  // Results that can be read straight off the protocol.
  localparam result_t RtcmEmptySkipped = '{
    event_res: EvRtcmSkip, payload_byte: 8'h00, payload_offset: 10'd0,
    msg_class: 8'h00, msg_ident: 8'h00, frame_length: 16'd0, route: RouteNone};
  localparam result_t OversizeRejected = '{
    event_res: EvUbxLenRj, payload_byte: 8'h00, payload_offset: 10'd0,
    msg_class: 8'hFF, msg_ident: 8'hFF, frame_length: 16'h0401, route: RouteNone};
  localparam result_t PvtEmptyGood = '{
    event_res: EvUbxGood, payload_byte: 8'h00, payload_offset: 10'd0,
    msg_class: ClassNav, msg_ident: IdentPvt, frame_length: 16'd0, route: RoutePvt};
  localparam result_t CovBadChecksum = '{
    event_res: EvUbxBadCk, payload_byte: 8'h00, payload_offset: 10'd0,
    msg_class: ClassNav, msg_ident: IdentCov, frame_length: 16'd1, route: RouteNone};

  // The opening script. A sync byte followed by the RTCM3 preamble restarts
  // as an RTCM3 frame whose first length byte has only junk in its upper six
  // bits, so the body is empty and just the three CRC bytes follow. Then a
  // doubled first sync byte, a UBX header whose length sits one above the
  // limit, an empty PVT frame with a correct checksum, and a one-byte
  // covariance frame (routing still off) whose second checksum byte is wrong.
  stim_row_t opening_rows [31] = '{
    '{8'hB5, 1'b0, '0}, '{8'hD3, 1'b0, '0}, '{8'hFC, 1'b0, '0},
    '{8'h00, 1'b0, '0}, '{8'hAA, 1'b0, '0}, '{8'h55, 1'b0, '0},
    '{8'hFF, 1'b1, RtcmEmptySkipped},
    '{8'hB5, 1'b0, '0}, '{8'hB5, 1'b0, '0}, '{8'h62, 1'b0, '0},
    '{8'hFF, 1'b0, '0}, '{8'hFF, 1'b0, '0}, '{8'h01, 1'b0, '0},
    '{8'h04, 1'b1, OversizeRejected},
    '{8'hB5, 1'b0, '0}, '{8'h62, 1'b0, '0}, '{8'h01, 1'b0, '0},
    '{8'h07, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0},
    '{8'h08, 1'b0, '0}, '{8'h19, 1'b1, PvtEmptyGood},
    '{8'hB5, 1'b0, '0}, '{8'h62, 1'b0, '0}, '{8'h01, 1'b0, '0},
    '{8'h36, 1'b0, '0}, '{8'h01, 1'b0, '0}, '{8'h00, 1'b0, '0},
    '{8'hFF, 1'b0, '0}, '{8'h37, 1'b0, '0},
    '{8'h00, 1'b1, CovBadChecksum}
  };

  // Every input of the deframer starts at a known value.
  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        rx_valid_i  = 1'b0;
  logic [7:0]  rx_byte_i   = 8'h00;
  logic        res_stall_i = 1'b0;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [2:0]  paddr       = 3'd0;
  logic [31:0] pwdata      = 32'd0;

  logic        rx_stall_o;
  logic        res_valid_o;
  logic [2:0]  event_res_o;
  logic [7:0]  payload_byte_o;
  logic [9:0]  payload_offset_o;
  logic [7:0]  msg_class_o;
  logic [7:0]  msg_ident_o;
  logic [15:0] frame_length_o;
  logic [1:0]  route_o;
  logic [31:0] prdata;
  logic        pready;

  // Results the deframer owes us, oldest first.
  result_t deframe_q [$];

  int unsigned fail_count = 0;
  int unsigned sent_bytes = 0;

  // Idle burst switches for the two channels, and the request for the one
  // long receiver hold-off.
  bit send_gaps     = 1'b1;
  bit recv_gaps     = 1'b1;
  bit long_hold_req = 1'b0;

  // Parser state kept by the bench. It starts at the reset state, and reset
  // is applied only once.
  parse_phase_e phase      = PhHunt;
  logic [7:0]   cls_seen   = 8'h00;
  logic [7:0]   ident_seen = 8'h00;
  logic [15:0]  frame_len  = 16'd0;
  logic [10:0]  count      = 11'd0;
  logic [7:0]   ck_a       = 8'h00;
  logic [7:0]   ck_b       = 8'h00;
  logic [7:0]   ck_a_rx    = 8'h00;
  logic         cov_route_on = 1'b0;

  gnss_ubx_rtcm_stream_deframer #(
    .MAX_PAYLOAD(MaxPayload)
  ) DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .rx_valid_i      (rx_valid_i),
    .rx_stall_o      (rx_stall_o),
    .rx_byte_i       (rx_byte_i),
    .res_valid_o     (res_valid_o),
    .res_stall_i     (res_stall_i),
    .event_res_o     (event_res_o),
    .payload_byte_o  (payload_byte_o),
    .payload_offset_o(payload_offset_o),
    .msg_class_o     (msg_class_o),
    .msg_ident_o     (msg_ident_o),
    .frame_length_o  (frame_length_o),
    .route_o         (route_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Fletcher-8 step shared by the frame builder and the parser model.
  function automatic void fletcher_add(inout logic [7:0] a, inout logic [7:0] s,
                                       input logic [7:0] x);
    a = a + x;
    s = s + a;
  endfunction

  // Where a byte seen outside a frame leads the hunt.
  function automatic parse_phase_e hunt_next(input logic [7:0] b);
    if (b == UbxSync1) return PhSync2;
    if (b == RtcmPre) return PhRtLenHi;
    return PhHunt;
  endfunction

  // Advances the parser model by one received byte and tells whether that
  // byte yields a result, and which.
  function automatic void deframe_step(input logic [7:0] b, output bit emits,
                                       output result_t r);
    emits = 1'b0;
    r = '0;
    case (phase)
      PhSync2: begin
        if (b == UbxSync2) begin
          ck_a = 8'h00;
          ck_b = 8'h00;
          phase = PhClass;
        end else begin
          phase = hunt_next(b);
        end
      end
      PhClass: begin
        cls_seen = b;
        fletcher_add(ck_a, ck_b, b);
        phase = PhIdent;
      end
      PhIdent: begin
        ident_seen = b;
        fletcher_add(ck_a, ck_b, b);
        phase = PhLenLo;
      end
      PhLenLo: begin
        frame_len = {8'h00, b};
        fletcher_add(ck_a, ck_b, b);
        phase = PhLenHi;
      end
      PhLenHi: begin
        frame_len[15:8] = b;
        fletcher_add(ck_a, ck_b, b);
        count = 11'd0;
        if (frame_len > 16'(MaxPayload)) begin
          phase = PhHunt;
          emits = 1'b1;
          r.event_res = EvUbxLenRj;
        end else begin
          phase = (frame_len == 16'd0) ? PhCkA : PhPayload;
        end
      end
      PhPayload: begin
        fletcher_add(ck_a, ck_b, b);
        emits = 1'b1;
        r.event_res = EvPayload;
        r.payload_byte = b;
        r.payload_offset = count[9:0];
        count = count + 11'd1;
        if ({5'd0, count} >= frame_len) phase = PhCkA;
      end
      PhCkA: begin
        ck_a_rx = b;
        phase = PhCkB;
      end
      PhCkB: begin
        phase = PhHunt;
        emits = 1'b1;
        if (ck_a_rx == ck_a && b == ck_b) begin
          r.event_res = EvUbxGood;
          if (cls_seen == ClassNav && ident_seen == IdentPvt) r.route = RoutePvt;
          else if (cls_seen == ClassNav && ident_seen == IdentCov && cov_route_on)
            r.route = RouteCov;
          else r.route = RouteNone;
        end else begin
          r.event_res = EvUbxBadCk;
        end
      end
      PhRtLenHi: begin
        // Only the two low bits of the first RTCM3 length byte count.
        frame_len = {6'd0, b[1:0], 8'h00};
        phase = PhRtLenLo;
      end
      PhRtLenLo: begin
        frame_len[7:0] = b;
        count = 11'd0;
        phase = PhRtBody;
      end
      PhRtBody: begin
        // The body is followed by three CRC bytes that are skipped unchecked.
        count = count + 11'd1;
        if (int'(count) >= int'(frame_len) + 3) begin
          phase = PhHunt;
          emits = 1'b1;
          r.event_res = EvRtcmSkip;
          r.frame_length = frame_len;
        end
      end
      default: phase = hunt_next(b);
    endcase
    // UBX results carry the latched header; an RTCM3 skip carries zero class and ident and its own length.
    if (emits && r.event_res != EvRtcmSkip) begin
      r.msg_class = cls_seen;
      r.msg_ident = ident_seen;
      r.frame_length = frame_len;
    end
  endfunction

  // Offers one byte, waits for its transfer, then books what it should
  // produce. A row with a typed result books that instead of the model's.
  task automatic transfer_byte(input logic [7:0] b, input logic typed = 1'b0,
                               input result_t typed_res = '0);
    bit      emits;
    result_t predicted;
    if (send_gaps && $urandom_range(0, 7) == 0) begin
      rx_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    rx_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (rx_stall_o);
    deframe_step(b, emits, predicted);
    if (typed) deframe_q.insert(deframe_q.size(), typed_res);
    else if (emits) deframe_q.insert(deframe_q.size(), predicted);
    sent_bytes++;
  endtask

  // Sends a complete UBX frame with random payload. With bad_ck set, one
  // bit of one checksum byte is flipped.
  task automatic send_ubx_frame(input logic [7:0] cls, input logic [7:0] idt,
                                input logic [15:0] len, input bit bad_ck);
    logic [7:0] hdr [4];
    logic [7:0] ca;
    logic [7:0] cb;
    logic [7:0] pb;
    hdr = '{cls, idt, len[7:0], len[15:8]};
    ca = 8'h00;
    cb = 8'h00;
    transfer_byte(UbxSync1);
    transfer_byte(UbxSync2);
    foreach (hdr[i]) begin
      fletcher_add(ca, cb, hdr[i]);
      transfer_byte(hdr[i]);
    end
    for (int i = 0; i < int'(len); i++) begin
      pb = 8'($urandom);
      fletcher_add(ca, cb, pb);
      transfer_byte(pb);
    end
    if (bad_ck) begin
      if ($urandom_range(0, 1)) ca ^= 8'(1 << $urandom_range(0, 7));
      else cb ^= 8'(1 << $urandom_range(0, 7));
    end
    transfer_byte(ca);
    transfer_byte(cb);
  endtask

  // Sends an RTCM3 frame; the unused upper bits of the first length byte
  // carry random junk.
  task automatic send_rtcm_frame(input logic [9:0] rlen);
    transfer_byte(RtcmPre);
    transfer_byte({6'($urandom), rlen[9:8]});
    transfer_byte(rlen[7:0]);
    repeat (int'(rlen) + 3) transfer_byte(8'($urandom));
  endtask

  // One random piece of the stream. Most of it is well-formed frames with
  // random content, biased toward the routed class and ids; the rest is
  // oversize headers, headers cut off part way, and line noise rich in
  // sync and preamble bytes.
  task automatic send_random_frame();
    int unsigned kind;
    logic [7:0]  cls;
    logic [7:0]  idt;
    logic [15:0] len;
    logic [7:0]  hdr [6];
    kind = $urandom_range(0, 99);
    cls = $urandom_range(0, 1) ? ClassNav : 8'($urandom);
    case ($urandom_range(0, 2))
      0: idt = IdentPvt;
      1: idt = IdentCov;
      default: idt = 8'($urandom);
    endcase
    if (kind < 60) begin
      len = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(13, 64))
                                         : 16'($urandom_range(0, 12));
      send_ubx_frame(cls, idt, len, $urandom_range(0, 6) == 0);
    end else if (kind < 75) begin
      send_rtcm_frame(10'($urandom_range(0, 15)));
    end else if (kind < 83) begin
      len = ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                        : 16'($urandom_range(MaxPayload + 1, 65535));
      hdr = '{UbxSync1, UbxSync2, cls, idt, len[7:0], len[15:8]};
      foreach (hdr[i]) transfer_byte(hdr[i]);
    end else if (kind < 92) begin
      repeat ($urandom_range(1, 6)) begin
        case ($urandom_range(0, 3))
          0: transfer_byte(UbxSync1);
          1: transfer_byte(UbxSync2);
          2: transfer_byte(RtcmPre);
          default: transfer_byte(8'($urandom));
        endcase
      end
    end else begin
      // A header that stops early; whatever follows is taken as its rest.
      hdr = '{UbxSync1, UbxSync2, cls, idt, 8'($urandom_range(0, 12)), 8'h00};
      for (int i = 0; i < int'($urandom_range(1, 5)); i++) transfer_byte(hdr[i]);
    end
  endtask

  task automatic run_random(input int unsigned n_bytes);
    int unsigned goal;
    goal = sent_bytes + n_bytes;
    while (sent_bytes < goal) send_random_frame();
  endtask

  // Stops offering bytes and waits until the deframer has delivered every
  // owed result and had time to finish any byte that yields none.
  task automatic settle_idle();
    rx_valid_i <= 1'b0;
    while (deframe_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Writes the covariance routing enable and reads it back.
  task automatic set_cov_routing(input logic en);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CovEnAddr;
    pwdata  <= {31'd0, en};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== {31'd0, en}) begin
      $error("cov_route_enable readback: expected 0x%0h, got 0x%0h", {31'd0, en}, prdata);
      fail_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    cov_route_on = en;
  endtask

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endfunction

  // Result side. Every transfer on the result channel is matched against
  // the oldest owed result, field by field.
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && res_valid_o && !res_stall_i) begin
      if (deframe_q.size() == 0) begin
        $error("result with nothing owed: event %0d", event_res_o);
        fail_count++;
      end else begin
        want = deframe_q.pop_front();
        check_field("event_res", 16'(want.event_res), 16'(event_res_o));
        check_field("payload_byte", 16'(want.payload_byte), 16'(payload_byte_o));
        check_field("payload_offset", 16'(want.payload_offset), 16'(payload_offset_o));
        check_field("msg_class", 16'(want.msg_class), 16'(msg_class_o));
        check_field("msg_ident", 16'(want.msg_ident), 16'(msg_ident_o));
        check_field("frame_length", want.frame_length, frame_length_o);
        check_field("route", 16'(want.route), 16'(route_o));
      end
    end
  end

  // Receiver stalls. Short random bursts while enabled, and once, on
  // request, a long hold-off during which the sender keeps offering bytes
  // so that the skid stage fills and the deframer stalls its input.
  initial begin
    forever begin
      @(posedge clk_i);
      if (long_hold_req) begin
        res_stall_i <= 1'b1;
        repeat (LongHoldCycles) @(posedge clk_i);
        res_stall_i <= 1'b0;
        long_hold_req = 1'b0;
      end else if (recv_gaps && $urandom_range(0, 5) == 0) begin
        res_stall_i <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
        res_stall_i <= 1'b0;
      end
    end
  end

  // Stimulus sequence.
  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Scripted opening with covariance routing at its reset value of off.
    foreach (opening_rows[i]) begin
      transfer_byte(opening_rows[i].rx, opening_rows[i].typed, opening_rows[i].res);
    end
    settle_idle();

    // Routing on. A long covariance frame runs through the long hold-off,
    // so the skid stage fills and the input stalls part way through it.
    set_cov_routing(1'b1);
    long_hold_req = 1'b1;
    send_ubx_frame(ClassNav, IdentCov, 16'd200, 1'b0);
    run_random(200);
    settle_idle();

    // Routing off, opening with an RTCM3 frame whose length uses bit 8.
    set_cov_routing(1'b0);
    send_rtcm_frame(10'h100 | 10'($urandom_range(0, 15)));
    run_random(150);
    settle_idle();

    // Routing on again, both channels at full rate to the end.
    set_cov_routing(1'b1);
    send_gaps = 1'b0;
    recv_gaps = 1'b0;
    run_random(150);
    settle_idle();

    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Run limit, far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
